### design/stack_with_median_query_core_macros.svh
// Assertion macros for the stack with median query core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef STACK_WITH_MEDIAN_QUERY_CORE_MACROS_SVH
`define STACK_WITH_MEDIAN_QUERY_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SMQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/smq_pkg.sv
// Shared types, constants and helpers for the stack with median query core.
// No dependencies.
`default_nettype none

package smq_pkg;

    localparam int STACK_DEPTH = 4096;
    localparam int VALUE_MAX   = 4096;

    // field width of values
    localparam int VAL_W  = 13;
    // stack address and count widths
    localparam int SA_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    // tree index width (indexes 0..VALUE_MAX)
    localparam int TI_W   = $clog2(VALUE_MAX + 1);

    // largest power of two not above VALUE_MAX (first descent step)
    function automatic int top_step(input int vmax);
        int s;
        s = 1;
        while (s <= vmax / 2)
            s = s * 2;
        return s;
    endfunction

    localparam int TOP_STEP = top_step(VALUE_MAX);

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_MEDIAN = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TM_ADD_UP,
        TM_ADD_DOWN,
        TM_SELECT
    } tree_mode_t;

    typedef struct packed {
        logic             start;
        tree_mode_t       mode;
        logic [TI_W-1:0]  value;
        logic [CNT_W-1:0] rank;
    } tree_req_t;

    typedef struct packed {
        logic idle;
        logic done;
    } tree_stat_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [VAL_W-1:0] value;
    } stack_cmd_t;

endpackage

`default_nettype wire

### design/smq_stack.sv
// LIFO value store and fill count for the median query core.
// Depends on smq_pkg.
`default_nettype none

module smq_stack (
    input  wire                       clk,
    input  wire                       rst_n,
    input  smq_pkg::stack_cmd_t       cmd,
    output logic [smq_pkg::CNT_W-1:0] count,
    output logic [smq_pkg::VAL_W-1:0] rd_data
);
    import smq_pkg::*;

    logic [VAL_W-1:0] stack_mem [0:STACK_DEPTH-1];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_dec;
    logic [VAL_W-1:0] rd_data_reg;

    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.pop)
            count_next = count_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // top-of-stack read is registered; data valid the cycle after pop
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stack_mem[count_reg[SA_W-1:0]] <= cmd.value;
        if (cmd.pop)
            rd_data_reg <= stack_mem[count_dec[SA_W-1:0]];
    end

    assign count   = count_reg;
    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/smq_fenwick.sv
// Binary indexed count tree with a small sequencer: clear sweep, point
// update walk and rank descent over one memory. Depends on smq_pkg.
`default_nettype none

module smq_fenwick (
    input  wire                      clk,
    input  wire                      rst_n,
    input  smq_pkg::tree_req_t       req,
    output smq_pkg::tree_stat_t      stat,
    output logic [smq_pkg::TI_W-1:0] result
);
    import smq_pkg::*;

    localparam int IW = TI_W + 1;
    localparam logic [IW-1:0]   VMAX_I = IW'(VALUE_MAX);
    localparam logic [TI_W-1:0] VMAX_T = TI_W'(VALUE_MAX);
    localparam logic [IW-1:0]   STEP0  = IW'(TOP_STEP);

    typedef enum logic [2:0] {
        F_CLEAR,
        F_IDLE,
        F_ADD_RD,
        F_ADD_WR,
        F_SEL_RD,
        F_SEL_CMP,
        F_SEL_END
    } fstate_t;

    logic [CNT_W-1:0] tree_mem [0:VALUE_MAX];

    fstate_t          state_reg,  state_next;
    logic [TI_W-1:0]  clr_reg,    clr_next;
    logic [IW-1:0]    idx_reg,    idx_next;
    logic             up_reg,     up_next;
    logic [IW-1:0]    pos_reg,    pos_next;
    logic [IW-1:0]    step_reg,   step_next;
    logic [CNT_W-1:0] rem_reg,    rem_next;
    logic [TI_W-1:0]  result_reg, result_next;
    logic             done_reg,   done_next;

    logic             rd_en;
    logic [TI_W-1:0]  rd_addr;
    logic [CNT_W-1:0] rd_data_reg;
    logic             wr_en;
    logic [TI_W-1:0]  wr_addr;
    logic [CNT_W-1:0] wr_data;

    logic [IW-1:0]    nxt;
    logic [IW-1:0]    idx_up;
    logic [IW-1:0]    pos_inc;

    assign nxt     = pos_reg + step_reg;
    assign idx_up  = idx_reg + (idx_reg & (~idx_reg + IW'(1)));
    assign pos_inc = pos_reg + IW'(1);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        up_next     = up_reg;
        pos_next    = pos_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        unique case (state_reg)
            F_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == VMAX_T)
                    state_next = F_IDLE;
                else
                    clr_next = clr_reg + TI_W'(1);
            end
            F_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.mode)
                        TM_ADD_UP, TM_ADD_DOWN:
                        begin
                            idx_next   = IW'(req.value);
                            up_next    = (req.mode == TM_ADD_UP);
                            state_next = F_ADD_RD;
                        end
                        TM_SELECT:
                        begin
                            pos_next   = '0;
                            step_next  = STEP0;
                            rem_next   = req.rank;
                            state_next = F_SEL_RD;
                        end
                        default:
                            state_next = F_IDLE;
                    endcase
                end
            end
            F_ADD_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg[TI_W-1:0];
                state_next = F_ADD_WR;
            end
            F_ADD_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[TI_W-1:0];
                wr_data  = up_reg ? rd_data_reg + CNT_W'(1) : rd_data_reg - CNT_W'(1);
                idx_next = idx_up;
                if (idx_up > VMAX_I)
                begin
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end
                else
                    state_next = F_ADD_RD;
            end
            F_SEL_RD:
            begin
                if (nxt <= VMAX_I)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = nxt[TI_W-1:0];
                    state_next = F_SEL_CMP;
                end
                else
                begin
                    // node past the end of the tree: halve the step only
                    step_next = step_reg >> 1;
                    if (step_reg == IW'(1))
                        state_next = F_SEL_END;
                end
            end
            F_SEL_CMP:
            begin
                if (rd_data_reg < rem_reg)
                begin
                    pos_next = nxt;
                    rem_next = rem_reg - rd_data_reg;
                end
                step_next = step_reg >> 1;
                if (step_reg == IW'(1))
                    state_next = F_SEL_END;
                else
                    state_next = F_SEL_RD;
            end
            F_SEL_END:
            begin
                result_next = (pos_inc > VMAX_I) ? VMAX_T : pos_inc[TI_W-1:0];
                done_next   = 1'b1;
                state_next  = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_CLEAR;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            idx_reg    <= '0;
            up_reg     <= 1'b0;
            pos_reg    <= '0;
            step_reg   <= '0;
            rem_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            idx_reg    <= idx_next;
            up_reg     <= up_next;
            pos_reg    <= pos_next;
            step_reg   <= step_next;
            rem_reg    <= rem_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tree_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= tree_mem[rd_addr];
    end

    assign stat.idle = (state_reg == F_IDLE);
    assign stat.done = done_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

### design/stack_with_median_query_core.sv
// Stack with lower-median query: top level, request decode and result register.
// Push: a tree update walk over up to log2(VALUE_MAX)+1 nodes. Pop: a stack read, then
// the same walk down. Median: a rank descent of log2(VALUE_MAX)+1 steps.
// Bad, full, empty and unused requests skip the tree; a stalled result adds its stall.
// After reset the count tree is swept to zero, one entry a cycle, VALUE_MAX+1 entries;
// in_stall is high through S_CLEAR. Rate is set by the one tree memory port.
`default_nettype none

`include "stack_with_median_query_core_macros.svh"

module stack_with_median_query_core (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_stall,
    input  wire  [1:0]                operation,
    input  wire  [smq_pkg::VAL_W-1:0] push_value,
    output logic                      out_valid,
    input  wire                       out_stall,
    output logic [1:0]                status,
    output logic [smq_pkg::VAL_W-1:0] result_value
);
    import smq_pkg::*;

    // S_CLEAR   : waiting for the tree clear sweep
    // S_IDLE    : ready for a request
    // S_POP_RD  : top-of-stack read in flight
    // S_TREE    : tree update or descent running
    // S_FINISH  : result waits for the output register
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_POP_RD,
        S_TREE,
        S_FINISH
    } state_t;

    state_t           state_reg,     state_next;
    logic             is_med_reg,    is_med_next;
    status_t          res_status_reg, res_status_next;
    logic [VAL_W-1:0] res_value_reg, res_value_next;
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [VAL_W-1:0] out_value_reg, out_value_next;

    stack_cmd_t       stk_cmd;
    logic [CNT_W-1:0] stk_count;
    logic [VAL_W-1:0] stk_rd_data;
    tree_req_t        tree_req;
    tree_stat_t       tree_stat;
    logic [TI_W-1:0]  tree_result;

    logic             accept;
    logic             val_bad;
    logic             stk_full;
    logic             stk_empty;
    logic             push_ok;
    logic [CNT_W:0]   rank_wide;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    // value check comes before the full check
    assign val_bad   = (push_value == '0) || (32'(push_value) > 32'(VALUE_MAX));
    assign stk_full  = (stk_count >= CNT_W'(STACK_DEPTH));
    assign stk_empty = (stk_count == '0);
    assign push_ok   = accept && (operation == OP_PUSH) && !val_bad && !stk_full;
    // lower-median rank (count+1)/2
    assign rank_wide = {1'b0, stk_count} + (CNT_W + 1)'(1);

    always_comb
    begin
        state_next      = state_reg;
        is_med_next     = is_med_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        stk_cmd         = '0;
        tree_req        = '0;
        tree_req.mode   = TM_ADD_UP;

        // output slot drains independently of the request side
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                if (tree_stat.idle)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_value_next  = '0;
                    is_med_next     = 1'b0;
                    state_next      = S_FINISH;
                    case (operation)
                        OP_PUSH:
                        begin
                            if (val_bad)
                                res_status_next = ST_BAD;
                            else if (stk_full)
                                res_status_next = ST_FULL;
                            else
                            begin
                                stk_cmd.push   = 1'b1;
                                stk_cmd.value  = push_value;
                                tree_req.start = 1'b1;
                                tree_req.mode  = TM_ADD_UP;
                                tree_req.value = TI_W'(push_value);
                                state_next     = S_TREE;
                            end
                        end
                        OP_POP:
                        begin
                            if (stk_empty)
                                res_status_next = ST_EMPTY;
                            else
                            begin
                                stk_cmd.pop = 1'b1;
                                state_next  = S_POP_RD;
                            end
                        end
                        OP_MEDIAN:
                        begin
                            if (stk_empty)
                                res_status_next = ST_EMPTY;
                            else
                            begin
                                tree_req.start = 1'b1;
                                tree_req.mode  = TM_SELECT;
                                tree_req.rank  = rank_wide[CNT_W:1];
                                is_med_next    = 1'b1;
                                state_next     = S_TREE;
                            end
                        end
                        default:
                        begin
                            // unused code: ok, value 0, nothing changes
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_POP_RD:
            begin
                res_value_next = stk_rd_data;
                tree_req.start = 1'b1;
                tree_req.mode  = TM_ADD_DOWN;
                tree_req.value = TI_W'(stk_rd_data);
                state_next     = S_TREE;
            end
            S_TREE:
            begin
                if (tree_stat.done)
                begin
                    if (is_med_reg)
                        res_value_next = VAL_W'(tree_result);
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            is_med_reg     <= 1'b0;
            res_status_reg <= ST_OK;
            res_value_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_value_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            is_med_reg     <= is_med_next;
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
        end
    end

    smq_stack u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (stk_cmd),
        .count   (stk_count),
        .rd_data (stk_rd_data)
    );

    smq_fenwick u_tree (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (tree_req),
        .stat   (tree_stat),
        .result (tree_result)
    );

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = out_value_reg;

    // checks
    `SMQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        stk_count <= CNT_W'(STACK_DEPTH), "stack count above depth")
    `SMQ_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && (status != ST_OK),
        result_value == '0, "nonzero value with error status")
    `SMQ_ASSERT_NEXT(a_push_count, clk, rst_n, push_ok,
        stk_count == $past(stk_count) + CNT_W'(1), "accepted push did not bump count")
    `SMQ_ASSERT_NOW(a_tree_idle, clk, rst_n, (state_reg == S_IDLE) || (state_reg == S_FINISH),
        tree_stat.idle, "tree busy while no request runs")

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for stack_with_median_query_core: push, pop and lower-median requests.
// Depends on smq_pkg and the core RTL only; it carries its own prediction of the stack and value counts.

module tb_top;
    import smq_pkg::*;

    // Quiet-cycle watchdog. It covers the reset sweep of the count tree,
    // the slowest request and the longest stall and gap bursts, with plenty
    // of margin.
    localparam int QUIET_LIMIT = 20000;
    localparam int RANDOM_REQUESTS = 1400;
    localparam int RAW_MAX = (1 << VAL_W) - 1;

    // Prediction of the stack contents and the per-value tally. The tally
    // feeds the median search, and the queue of expected results is checked
    // in order.
    class median_stack_board;
        logic [VAL_W-1:0] stored_vals[$];
        int unsigned      value_tally[VALUE_MAX+1];
        status_t          due_status[$];
        logic [VAL_W-1:0] due_value[$];
        int mismatches;
        int peak_depth;
        int n_push;
        int n_pop;
        int n_median;
        int n_unused;
        int status_seen[4];

        function int depth();
            return stored_vals.size();
        endfunction

        function int pending();
            return due_status.size();
        endfunction

        // smallest value whose running tally reaches rank (count+1)/2
        function logic [VAL_W-1:0] lower_median();
            int rank;
            int acc;
            rank = (stored_vals.size() + 1) / 2;
            acc = 0;
            for (int v = 1; v <= VALUE_MAX; v++)
            begin
                acc += value_tally[v];
                if (acc >= rank)
                    return VAL_W'(v);
            end
            return VAL_W'(VALUE_MAX);
        endfunction

        function void note_request(logic [1:0] op, logic [VAL_W-1:0] val);
            status_t          st;
            logic [VAL_W-1:0] res;
            st = ST_OK;
            res = '0;
            case (op)
                OP_PUSH:
                begin
                    n_push++;
                    // the value check wins over the full check
                    if (val == 0 || val > VALUE_MAX)
                        st = ST_BAD;
                    else if (stored_vals.size() >= STACK_DEPTH)
                        st = ST_FULL;
                    else
                    begin
                        stored_vals.push_back(val);
                        value_tally[val]++;
                        if (stored_vals.size() > peak_depth)
                            peak_depth = stored_vals.size();
                    end
                end
                OP_POP:
                begin
                    n_pop++;
                    if (stored_vals.size() == 0)
                        st = ST_EMPTY;
                    else
                    begin
                        res = stored_vals.pop_back();
                        value_tally[res]--;
                    end
                end
                OP_MEDIAN:
                begin
                    n_median++;
                    if (stored_vals.size() == 0)
                        st = ST_EMPTY;
                    else
                        res = lower_median();
                end
                default:
                    n_unused++;   // unused code: ok, zero, no change
            endcase
            status_seen[st]++;
            due_status.push_back(st);
            due_value.push_back(res);
        endfunction

        function void check_result(logic [1:0] st, logic [VAL_W-1:0] val);
            status_t          want_st;
            logic [VAL_W-1:0] want_val;
            if (due_status.size() == 0)
            begin
                $error("result with no request outstanding: status %0d, result_value %0d",
                       st, val);
                mismatches++;
                return;
            end
            want_st = due_status.pop_front();
            want_val = due_value.pop_front();
            if (st !== want_st)
            begin
                $error("status mismatch: expected %0d, actual %0d", want_st, st);
                mismatches++;
            end
            if (val !== want_val)
            begin
                $error("result_value mismatch: expected %0d, actual %0d", want_val, val);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [1:0]       operation = OP_PUSH;
    logic [VAL_W-1:0] push_value = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [1:0]       status;
    logic [VAL_W-1:0] result_value;

    median_stack_board board;

    // idling switches, flipped per random segment; both off at the end
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;

    stack_with_median_query_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_value (result_value)
    );

    always #5 clk = ~clk;

    // Receiver: random stall bursts, driven at the falling edge.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (rx_idle_on && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(1, 18) - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // Result monitor: a result moves on a rising edge with valid high and stall low.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(status, result_value);
    end

    // Watchdog on cycles where neither channel moves anything.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // One request: optional gap burst, then hold valid and payload until the
    // block takes it. The prediction is updated at the accepting edge.
    task automatic send_request(input logic [1:0] op, input logic [VAL_W-1:0] val);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            in_valid <= 1'b0;
            operation <= 2'($urandom_range(0, 3));
            push_value <= VAL_W'($urandom_range(0, RAW_MAX));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        push_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(op, val);
    endtask

    // Legal push values in a few shapes: heavy duplicates, full range,
    // crowded at the top, and single bits.
    function automatic logic [VAL_W-1:0] pick_value(int shape);
        case (shape)
            0:       return VAL_W'($urandom_range(1, 8));
            1:       return VAL_W'($urandom_range(1, VALUE_MAX));
            2:       return VAL_W'($urandom_range(VALUE_MAX - 8, VALUE_MAX));
            default: return VAL_W'(1 << $urandom_range(0, VAL_W - 1));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] bad_value();
        if ($urandom_range(0, 3) == 0)
            return '0;
        return VAL_W'($urandom_range(VALUE_MAX + 1, RAW_MAX));
    endfunction

    function automatic logic [VAL_W-1:0] junk();
        return VAL_W'($urandom_range(0, RAW_MAX));
    endfunction

    initial
    begin
        int sent;
        int seg_len;
        int push_w;
        int pop_w;
        int shape;
        int r;

        board = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty stack, unused code, bad values at both ends,
        // extreme values, duplicates in the median and a drain to empty.
        send_request(OP_MEDIAN, junk());
        send_request(OP_POP, junk());
        send_request(2'd3, VAL_W'(RAW_MAX));
        send_request(OP_PUSH, '0);
        send_request(OP_PUSH, VAL_W'(VALUE_MAX + 1));
        send_request(OP_PUSH, VAL_W'(RAW_MAX));
        send_request(OP_PUSH, VAL_W'(1));
        send_request(OP_PUSH, VAL_W'(VALUE_MAX));
        send_request(OP_PUSH, VAL_W'(VALUE_MAX));
        send_request(OP_MEDIAN, junk());
        send_request(OP_PUSH, VAL_W'(1));
        send_request(OP_MEDIAN, junk());
        send_request(OP_POP, junk());
        send_request(OP_POP, junk());
        send_request(OP_MEDIAN, junk());
        send_request(OP_POP, junk());
        send_request(OP_POP, junk());
        send_request(OP_POP, junk());
        send_request(OP_MEDIAN, junk());
        send_request(OP_PUSH, VAL_W'(VALUE_MAX / 2));
        send_request(OP_PUSH, VAL_W'(VALUE_MAX / 2 - 1));
        send_request(OP_MEDIAN, junk());
        send_request(OP_POP, junk());
        send_request(OP_POP, junk());
        send_request(2'd3, '0);

        // Random segments: each has its own growth bias, value shape and
        // idling mix, so the depth wanders and both sides stall at times.
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       begin push_w = 60; pop_w = 20; end
                1:       begin push_w = 25; pop_w = 50; end
                default: begin push_w = 40; pop_w = 35; end
            endcase
            shape = $urandom_range(0, 3);
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < seg_len; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < push_w)
                    send_request(OP_PUSH, pick_value(shape));
                else if (r < push_w + pop_w)
                    send_request(OP_POP, junk());
                else if (r < 95)
                    send_request(OP_MEDIAN, junk());
                else if (r < 98)
                    send_request(OP_PUSH, bad_value());
                else
                    send_request(2'd3, junk());
                sent++;
            end
        end

        // Last part, no idling: a push-heavy run back to back, the bad-value
        // cases on a deep stack, then pop part of the way back down.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int k = 0; k < 96; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_request(OP_MEDIAN, junk());
            else
                send_request(OP_PUSH, pick_value($urandom_range(0, 3)));
        end
        send_request(OP_PUSH, '0);
        send_request(OP_PUSH, VAL_W'(RAW_MAX));
        send_request(OP_PUSH, VAL_W'(VALUE_MAX + 1));
        send_request(OP_MEDIAN, junk());
        send_request(2'd3, junk());
        for (int k = 0; k < 48; k++)
        begin
            send_request(OP_POP, junk());
            if (k % 4 == 3)
                send_request(OP_MEDIAN, junk());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then give a stray late result time to show up
        while (board.pending() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Ran %0d pushes, %0d pops, %0d median queries, %0d unused codes; peak depth %0d, final depth %0d.",
                 board.n_push, board.n_pop, board.n_median, board.n_unused, board.peak_depth,
                 board.depth());
        $display("Statuses: %0d ok, %0d empty, %0d full, %0d bad value; %0d mismatches.",
                 board.status_seen[ST_OK], board.status_seen[ST_EMPTY],
                 board.status_seen[ST_FULL], board.status_seen[ST_BAD], board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
